[hdl/sacrt_pkg.sv]
package sacrt_pkg;

  localparam int SET_COUNT    = 16;
  localparam int WAY_COUNT    = 4;
  localparam int OFFSET_BITS  = 5;
  localparam int ADDRESS_BITS = 19;
  localparam int TAG_BITS     = 10;
  localparam int SET_BITS     = $clog2(SET_COUNT);
  localparam int WAY_BITS     = $clog2(WAY_COUNT);
  localparam int AGE_BITS     = WAY_BITS;
  localparam int LINE_BITS    = 14;
  localparam int CNT_BITS     = 32;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_PLRU = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [ADDRESS_BITS-1:0] byte_address;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_BITS-1:0]  way_used;
    logic                 evicted;
    logic [LINE_BITS-1:0] evicted_line;
    logic [CNT_BITS-1:0]  hit_total;
    logic [CNT_BITS-1:0]  access_total;
  } out_item_t;

  // one way of a set as kept in the set memory
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic                valid;
    logic [AGE_BITS-1:0] age;
    logic                mru;
  } way_ent_t;

  typedef way_ent_t [WAY_COUNT-1:0] set_row_t;

  typedef struct packed {
    logic capture;  // latch item, launch set read
    logic update;   // evaluate, write set back, emit result
  } ctl_cmd_t;

endpackage

[hdl/set_assoc_cache_replacement_tracker.sv]
// Channel  | Ports                         | Handshake
// ---------+-------------------------------+-----------------------------------
// input    | start, busy, in_item          | taken when start && !busy
// result   | out_strobe, out_item          | one cycle pulse, cannot be held off
// config   | cfg_we, cfg_wdata             | policy_mode written when cfg_we
//
// An item goes through the block in order: first its set row is read from
// the set memory, then tags are compared, the way is picked and the row is
// written back. The result is registered and shows on the cycle after that,
// when busy is already low; a new item is not taken before the write-back.
// Reset (rst_n low, sync) empties every set through per-set row-valid flops;
// no clearing pass is needed. Counters and policy clear to zero (true LRU).
module set_assoc_cache_replacement_tracker import sacrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  // item in
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  // policy register
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  // result out
  output logic      out_strobe,
  output out_item_t out_item
);

  ctl_cmd_t cmd;

  // sequencer: idle -> eval -> idle
  sacrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // set memory, lookup, LRU/pLRU update, counters and result register
  sacrt_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

[hdl/sacrt_ctrl.sv]
module sacrt_ctrl import sacrt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output ctl_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign cmd.capture = (state_r == ST_IDLE) && start;
  assign cmd.update  = (state_r == ST_EVAL);

endmodule

[hdl/sacrt_dpath.sv]
module sacrt_dpath import sacrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_cmd_t  cmd,
  input  in_item_t  in_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output logic      out_strobe,
  output out_item_t out_item
);

  set_row_t set_mem [SET_COUNT];

  logic [SET_COUNT-1:0]    row_ok_r;
  logic                    policy_r;
  logic [CNT_BITS-1:0]     hit_cnt_r;
  logic [CNT_BITS-1:0]     acc_cnt_r;
  logic [ADDRESS_BITS-1:0] addr_r;
  set_row_t                rd_row_r;
  logic                    strobe_r;
  out_item_t               out_r;

  logic [SET_BITS-1:0] in_set;
  logic [SET_BITS-1:0] set_idx;
  logic [TAG_BITS-1:0] tag;

  set_row_t             cur_row;
  set_row_t             new_row;
  logic                 hit;
  logic                 found;
  logic                 free_found;
  logic [WAY_BITS-1:0]  hit_way;
  logic [WAY_BITS-1:0]  free_way;
  logic [WAY_BITS-1:0]  vic_way;
  logic [WAY_BITS-1:0]  way;
  logic                 plru_found;
  logic [WAY_BITS-1:0]  plru_way;
  logic [WAY_BITS-1:0]  lru_way;
  logic [AGE_BITS-1:0]  best_age;
  logic                 was_valid;
  logic [AGE_BITS:0]    old_age;
  logic                 all_valid;
  logic                 all_mru;
  logic                 evict;
  logic [CNT_BITS-1:0]  hit_cnt_nxt;
  logic [CNT_BITS-1:0]  acc_cnt_nxt;
  out_item_t            out_nxt;

  assign in_set  = SET_BITS'(in_item.byte_address >> OFFSET_BITS);
  assign set_idx = SET_BITS'(addr_r >> OFFSET_BITS);
  assign tag     = TAG_BITS'(addr_r >> (OFFSET_BITS + SET_BITS));

  always_comb begin
    // a set never written reads as empty
    cur_row = rd_row_r;
    if (!row_ok_r[set_idx]) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        cur_row[w].valid = 1'b0;
        cur_row[w].age   = '0;
        cur_row[w].mru   = 1'b0;
      end
    end

    // lookup and victim choice
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    plru_found = 1'b0;
    plru_way   = '0;
    lru_way    = '0;
    best_age   = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!hit && cur_row[w].valid && cur_row[w].tag == tag) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!free_found && !cur_row[w].valid) begin
        free_found = 1'b1;
        free_way   = WAY_BITS'(w);
      end
      if (!plru_found && !cur_row[w].mru) begin
        plru_found = 1'b1;
        plru_way   = WAY_BITS'(w);
      end
      if (cur_row[w].age > best_age) begin
        best_age = cur_row[w].age;
        lru_way  = WAY_BITS'(w);
      end
    end
    found   = free_found;
    vic_way = (policy_r == POLICY_PLRU) ? plru_way : lru_way;
    way     = hit ? hit_way : (found ? free_way : vic_way);
    evict   = !hit && !found;

    // touch: ages and MRU bits both tracked
    was_valid = hit || !found;
    old_age   = was_valid ? {1'b0, cur_row[way].age} : (AGE_BITS+1)'(WAY_COUNT);
    new_row   = cur_row;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (WAY_BITS'(w) != way && cur_row[w].valid && {1'b0, cur_row[w].age} < old_age) begin
        new_row[w].age = cur_row[w].age + AGE_BITS'(1);
      end
    end
    new_row[way].age   = '0;
    new_row[way].tag   = tag;
    new_row[way].valid = 1'b1;
    new_row[way].mru   = 1'b1;
    all_valid = 1'b1;
    all_mru   = 1'b1;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!new_row[w].valid) all_valid = 1'b0;
      if (!new_row[w].mru)   all_mru   = 1'b0;
    end
    if (all_valid && all_mru) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        new_row[w].mru = (WAY_BITS'(w) == way);
      end
    end

    // saturating counters
    acc_cnt_nxt = (&acc_cnt_r) ? acc_cnt_r : acc_cnt_r + CNT_BITS'(1);
    hit_cnt_nxt = (hit && !(&hit_cnt_r)) ? hit_cnt_r + CNT_BITS'(1) : hit_cnt_r;

    out_nxt.hit          = hit;
    out_nxt.way_used     = way;
    out_nxt.evicted      = evict;
    out_nxt.evicted_line = evict ? LINE_BITS'({cur_row[way].tag, set_idx}) : '0;
    out_nxt.hit_total    = hit_cnt_nxt;
    out_nxt.access_total = acc_cnt_nxt;
  end

  // set memory: read on capture, write back on update
  always_ff @(posedge clk) begin
    if (cmd.capture) rd_row_r <= set_mem[in_set];
    if (cmd.update)  set_mem[set_idx] <= new_row;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) addr_r <= in_item.byte_address;
    if (cmd.update)  out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r  <= '0;
      policy_r  <= POLICY_LRU;
      hit_cnt_r <= '0;
      acc_cnt_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      if (cfg_we) policy_r <= cfg_wdata;
      strobe_r <= cmd.update;
      if (cmd.update) begin
        row_ok_r[set_idx] <= 1'b1;
        hit_cnt_r         <= hit_cnt_nxt;
        acc_cnt_r         <= acc_cnt_nxt;
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

[hdl/sacrt_chk.sv]
module sacrt_chk import sacrt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);

  // an accepted item locks the input for its evaluation
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // each accepted item raises out_strobe once its evaluation is done
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("result missing two cycles after accept");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without an item in flight");

  a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.hit) |-> (!out_item.evicted && out_item.evicted_line == '0))
    else $error("hit reported an eviction");

  a_counter_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.hit_total <= out_item.access_total))
    else $error("hit count above access count");

endmodule

bind set_assoc_cache_replacement_tracker sacrt_chk u_sacrt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

[tb/tb_set_assoc_cache_replacement_tracker.sv]
`timescale 1ns / 1ps

module tb_set_assoc_cache_replacement_tracker;
  import sacrt_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      out_strobe;
  out_item_t out_item;

  set_assoc_cache_replacement_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the tag store: tags, valid bits, LRU ages, MRU bits, counters
  // and the policy bit. Updated at the edge where the block takes each item;
  // the policy bit at the edge where cfg_we is sampled.
  logic [TAG_BITS-1:0] tag_mem   [SET_COUNT][WAY_COUNT];
  logic                valid_mem [SET_COUNT][WAY_COUNT];
  logic [AGE_BITS-1:0] age_mem   [SET_COUNT][WAY_COUNT];
  logic                mru_mem   [SET_COUNT][WAY_COUNT];
  logic [CNT_BITS-1:0] hit_cnt;
  logic [CNT_BITS-1:0] access_cnt;
  logic                policy;

  in_item_t  access_queue[$];      // accesses waiting to be issued
  out_item_t lookup_results[$];    // predicted results, oldest first
  bit        item_taken = 1'b0;    // an item went in at the last rising edge
  int        idle_pct = 30;        // chance in 100 that the sender idles a cycle
  int        mismatch_count = 0;

  // Mark a way most recently used in both trackers. A fresh fill counts as
  // older than every valid way, so all valid ways age by one.
  function automatic void mark_recent(int s, int w, bit was_valid);
    int old_age;
    bit full;
    bit all_set;
    old_age = was_valid ? int'(age_mem[s][w]) : WAY_COUNT;
    full = 1'b1;
    all_set = 1'b1;
    for (int v = 0; v < WAY_COUNT; v++) begin
      if (v != w && valid_mem[s][v] && int'(age_mem[s][v]) < old_age)
        age_mem[s][v] = age_mem[s][v] + 1'b1;
    end
    age_mem[s][w] = '0;
    mru_mem[s][w] = 1'b1;
    for (int v = 0; v < WAY_COUNT; v++) begin
      if (!valid_mem[s][v]) full = 1'b0;
      if (!mru_mem[s][v]) all_set = 1'b0;
    end
    // full set with every MRU bit up: clear all but the way just used
    if (full && all_set) begin
      for (int v = 0; v < WAY_COUNT; v++) mru_mem[s][v] = 1'b0;
      mru_mem[s][w] = 1'b1;
    end
  endfunction

  // One access: look up, fill or replace, update trackers and counters.
  function automatic out_item_t predict_lookup(in_item_t it);
    logic [LINE_BITS-1:0] line;
    logic [TAG_BITS-1:0]  tg;
    int                   s;
    int                   way;
    int                   oldest;
    bit                   found;
    out_item_t            r;
    line = LINE_BITS'(it.byte_address >> OFFSET_BITS);
    s    = int'(line[SET_BITS-1:0]);
    tg   = TAG_BITS'(line >> SET_BITS);
    r    = '0;
    way  = 0;
    found = 1'b0;
    if (access_cnt != '1) access_cnt = access_cnt + 1'b1;

    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!found && valid_mem[s][w] && tag_mem[s][w] == tg) begin
        found = 1'b1;
        way = w;
      end
    end

    if (found) begin
      r.hit = 1'b1;
      if (hit_cnt != '1) hit_cnt = hit_cnt + 1'b1;
      mark_recent(s, way, 1'b1);
    end else begin
      // empty ways fill lowest first
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (!found && !valid_mem[s][w]) begin
          found = 1'b1;
          way = w;
        end
      end
      if (found) begin
        tag_mem[s][way] = tg;
        valid_mem[s][way] = 1'b1;
        mark_recent(s, way, 1'b0);
      end else begin
        if (policy == POLICY_PLRU) begin
          // first way with its MRU bit clear, way 0 if none
          way = 0;
          for (int w = 0; w < WAY_COUNT; w++) begin
            if (!found && !mru_mem[s][w]) begin
              found = 1'b1;
              way = w;
            end
          end
        end else begin
          // oldest age, lowest way on a tie
          oldest = 0;
          way = 0;
          for (int w = 0; w < WAY_COUNT; w++) begin
            if (int'(age_mem[s][w]) > oldest) begin
              oldest = int'(age_mem[s][w]);
              way = w;
            end
          end
        end
        r.evicted = 1'b1;
        r.evicted_line = LINE_BITS'({tag_mem[s][way], SET_BITS'(s)});
        tag_mem[s][way] = tg;
        mark_recent(s, way, 1'b1);
      end
    end

    r.way_used     = WAY_BITS'(way);
    r.hit_total    = hit_cnt;
    r.access_total = access_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. Prediction first, so an
  // item and its result could even share an edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      foreach (valid_mem[s, w]) begin
        tag_mem[s][w]   = '0;
        valid_mem[s][w] = 1'b0;
        age_mem[s][w]   = '0;
        mru_mem[s][w]   = 1'b0;
      end
      hit_cnt    = '0;
      access_cnt = '0;
      policy     = POLICY_LRU;
      item_taken = 1'b0;
    end else begin
      item_taken = start && !busy;
      if (item_taken)
        lookup_results.insert(lookup_results.size(), predict_lookup(in_item));
      if (cfg_we) policy = cfg_wdata;

      if (out_strobe) begin
        if (lookup_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with none pending: %p", $realtime, out_item);
        end else begin
          want = lookup_results.pop_front();
          if (out_item.hit !== want.hit || out_item.way_used !== want.way_used ||
              out_item.evicted !== want.evicted ||
              out_item.evicted_line !== want.evicted_line ||
              out_item.hit_total !== want.hit_total ||
              out_item.access_total !== want.access_total) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch exp hit=%0d way=%0d ev=%0d line=%h hits=%0d acc=%0d",
                       $realtime, want.hit, want.way_used, want.evicted,
                       want.evicted_line, want.hit_total, want.access_total,
                       "\n            got hit=%0d way=%0d ev=%0d line=%h hits=%0d acc=%0d",
                       out_item.hit, out_item.way_used, out_item.evicted,
                       out_item.evicted_line, out_item.hit_total, out_item.access_total);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: changes inputs at the falling edge. A raised start stays up with
  // the same item until the block takes it; idle cycles only fall between.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && !(start && !item_taken)) begin
      if (start) void'(access_queue.pop_front());
      if (access_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start   <= 1'b1;
        in_item <= access_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // queue one access to a given tag, set and line offset
  task automatic push_access(bit act, int tg, int s, int off);
    in_item_t it;
    it.action       = act;
    it.byte_address = ADDRESS_BITS'({TAG_BITS'(tg), SET_BITS'(s), OFFSET_BITS'(off)});
    access_queue.insert(access_queue.size(), it);
  endtask

  // wait for the block to drain, then a few cycles of margin
  task automatic wait_drained();
    while (access_queue.size() != 0 || start || lookup_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // policy write, only while the block is idle
  task automatic write_policy(logic mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int        r;
    int        hot_base;
    in_item_t  it;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // true LRU on set 0: fills, hits, two evictions; address extremes
    write_policy(POLICY_LRU);
    push_access(0, 0, 0, 0);          // empty fill way 0
    push_access(1, 0, 0, 31);         // hit, last byte of the line
    push_access(0, 10'h3FF, 15, 31);  // all-ones address
    push_access(1, 1, 0, 0);
    push_access(0, 2, 0, 5);
    push_access(1, 3, 0, 7);          // set 0 now full
    push_access(0, 0, 0, 0);          // hit, tag 1 becomes oldest
    push_access(1, 4, 0, 0);          // evicts tag 1
    push_access(0, 2, 0, 0);          // hit
    push_access(0, 5, 0, 0);          // evicts tag 3
    wait_drained();

    // bit pLRU on set 2: MRU clearing on fill and on hit, then victims
    write_policy(POLICY_PLRU);
    push_access(0, 0, 2, 0);
    push_access(1, 1, 2, 0);
    push_access(0, 2, 2, 0);
    push_access(1, 3, 2, 0);          // set full, all MRU bits up: cleared
    push_access(0, 4, 2, 0);          // victim way 0
    push_access(1, 1, 2, 3);          // hit
    push_access(0, 2, 2, 9);          // hit, all bits up again: cleared
    push_access(1, 5, 2, 0);          // victim way 0
    push_access(0, 6, 2, 0);          // victim way 1
    wait_drained();

    // random phases, policy alternates without reset; one phase never idles
    for (int p = 0; p < 6; p++) begin
      write_policy(p[0] ? POLICY_LRU : POLICY_PLRU);
      idle_pct = (p == 2) ? 0 : 30;
      hot_base = $urandom_range(0, 1015);
      for (int n = 0; n < 300; n++) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          // small tag pool per set: more tags than ways, so hits and evictions
          push_access(1'($urandom_range(0, 1)), hot_base + $urandom_range(0, 5),
                      $urandom_range(0, 15), $urandom_range(0, 31));
        end else if (r < 92) begin
          it.action       = 1'($urandom_range(0, 1));
          it.byte_address = ADDRESS_BITS'($urandom);
          access_queue.insert(access_queue.size(), it);
        end else begin
          push_access(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? 10'h3FF : 0,
                      $urandom_range(0, 1) ? 15 : 0, $urandom_range(0, 1) ? 31 : 0);
        end
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && lookup_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
